// ----- hdl/ser_pkg.sv -----
// ser_pkg: shared types and constants for the sequenced event ring.
// Holds the controller state type, operation and result codes, and fixed widths and limits.
// No dependencies.
package ser_pkg;

  localparam int SEQ_W     = 32;
  localparam int COUNT_W   = 7;
  localparam int PORT_PL_W = 64;

  localparam logic [SEQ_W-1:0]   TOP_SEQ     = 32'hFFFF_FFFF;
  localparam logic [COUNT_W-1:0] MAX_DELIVER = 7'd64;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_EVENT = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DELIVER
  } ser_state_t;

endpackage

// ----- hdl/ser_ring_mem.sv -----
// ser_ring_mem: event payload store, one write port and one registered read port.
// Read data is registered, appears in the cycle after the read enable and holds until the next read.
// No dependencies.
module ser_ring_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/sequenced_event_ring.sv -----
// sequenced_event_ring: ring of event payloads numbered by a running head sequence.
// Adds store at the write pointer unless head is at the top sequence; read-since queries stream stored events out.
// Depends on ser_pkg and ser_ring_mem.
//
//   channel  signals                          direction  payload
//   in       in_valid / in_stall              receive    operation, event_payload_in,
//                                                        payload_present, since_seq, max_count
//   out      out_valid / out_stall            send       result_kind, accepted, event_seq,
//                                                        event_payload_out, next_seq,
//                                                        dropped_count, last
//   cfg      cfg_wr_en / cfg_wr_data          receive    default_payload
//
// An add is handled in the idle state and its acknowledgement sits in the output register.
// A query does the sequence arithmetic in ST_CALC, then streams one event per cycle
// through the single read port of the store. A stall on the output holds the stream;
// input is taken only while idle with the output register free. Reset clears head
// and the write pointer; the store is not cleared, as only written slots are ever read.
module sequenced_event_ring
  import ser_pkg::*;
#(
  parameter int RING_DEPTH   = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 operation,
  input  logic [PORT_PL_W-1:0] event_payload_in,
  input  logic                 payload_present,
  input  logic [SEQ_W-1:0]     since_seq,
  input  logic [COUNT_W-1:0]   max_count,
  // output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           result_kind,
  output logic                 accepted,
  output logic [SEQ_W-1:0]     event_seq,
  output logic [PORT_PL_W-1:0] event_payload_out,
  output logic [SEQ_W-1:0]     next_seq,
  output logic [SEQ_W-1:0]     dropped_count,
  output logic                 last,
  // configuration
  input  logic                 cfg_wr_en,
  input  logic [PORT_PL_W-1:0] cfg_wr_data
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;

  ser_state_t state, state_next;

  logic [PAYLOAD_BITS-1:0] default_payload;
  logic [SEQ_W-1:0]        head_seq;
  logic [IDX_W-1:0]        wptr;
  logic [IDX_W-1:0]        wptr_inc;

  // query set-up registers
  logic                    q_beyond;
  logic [SEQ_W-1:0]        q_diff;
  logic [SEQ_W-1:0]        q_since;
  logic [COUNT_W-1:0]      q_maxc;
  logic [SEQ_W-1:0]        q_dropped;
  logic [SEQ_W:0]          diff_wide;
  logic [COUNT_W-1:0]      maxc_clamped;

  // delivery registers
  logic [IDX_W-1:0]        rd_ptr;
  logic [IDX_W-1:0]        rd_ptr_inc;
  logic [CNT_W-1:0]        remaining;
  logic [SEQ_W-1:0]        issue_seq;
  logic                    pend;
  logic [SEQ_W-1:0]        pend_seq;
  logic                    pend_last;

  // set-up arithmetic
  logic                    c_over;
  logic [SEQ_W-1:0]        c_dropped;
  logic [CNT_W-1:0]        c_avail;
  logic [SEQ_W-1:0]        c_since;
  logic [CNT_W-1:0]        c_n;
  logic [SUM_W-1:0]        c_sum;
  logic [IDX_W-1:0]        c_start;

  logic                    out_free;
  logic                    load_add;
  logic                    take_query;
  logic                    load_term;
  logic                    load_evt;
  logic                    issue;
  logic                    store_wr;
  logic [PAYLOAD_BITS-1:0] add_payload;
  logic [PAYLOAD_BITS-1:0] mem_rd_data;

  assign out_free     = !out_valid || !out_stall;
  assign wptr_inc     = (wptr == IDX_W'(RING_DEPTH - 1)) ? '0 : wptr + IDX_W'(1);
  assign rd_ptr_inc   = (rd_ptr == IDX_W'(RING_DEPTH - 1)) ? '0 : rd_ptr + IDX_W'(1);
  assign store_wr     = load_add && (head_seq != TOP_SEQ);
  assign add_payload  = payload_present ? event_payload_in[PAYLOAD_BITS-1:0] : default_payload;
  assign diff_wide    = {1'b0, head_seq} - {1'b0, since_seq};
  assign maxc_clamped = (max_count > MAX_DELIVER) ? MAX_DELIVER : max_count;

  // Clip the reader's backlog to what the ring still holds.
  assign c_over    = q_diff > SEQ_W'(RING_DEPTH);
  assign c_dropped = c_over ? q_diff - SEQ_W'(RING_DEPTH) : '0;
  assign c_avail   = c_over ? CNT_W'(RING_DEPTH) : q_diff[CNT_W-1:0];
  assign c_since   = c_over ? head_seq - SEQ_W'(RING_DEPTH) : q_since;
  assign c_n       = (COUNT_W'(c_avail) < q_maxc) ? c_avail : q_maxc[CNT_W-1:0];
  // First slot to read: write pointer stepped back by the backlog, wrapped.
  assign c_sum     = SUM_W'(wptr) + SUM_W'(RING_DEPTH) - SUM_W'(c_avail);
  assign c_start   = (c_sum >= SUM_W'(RING_DEPTH)) ? IDX_W'(c_sum - SUM_W'(RING_DEPTH))
                                                   : IDX_W'(c_sum);

  ser_ring_mem #(
    .DEPTH (RING_DEPTH),
    .WIDTH (PAYLOAD_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (wptr),
    .wr_data (add_payload),
    .rd_en   (issue),
    .rd_addr (rd_ptr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    load_add   = 1'b0;
    take_query = 1'b0;
    load_term  = 1'b0;
    load_evt   = 1'b0;
    issue      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = !out_free;
        if (in_valid && out_free) begin
          if (operation == OP_ADD) begin
            load_add = 1'b1;
          end else begin
            take_query = 1'b1;
            state_next = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        if (out_free) begin
          if (q_beyond || (c_n == '0)) begin
            load_term  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_DELIVER;
          end
        end
      end
      ST_DELIVER: begin
        load_evt = pend && out_free;
        // read the next slot only when the read register will be free
        issue    = (remaining != '0) && (!pend || out_free);
        if ((remaining == '0) && load_evt) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      head_seq        <= '0;
      wptr            <= '0;
      pend            <= 1'b0;
      remaining       <= '0;
      default_payload <= '0;
    end else begin
      if (cfg_wr_en) begin
        default_payload <= cfg_wr_data[PAYLOAD_BITS-1:0];
      end
      if (load_add || load_term || load_evt) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (store_wr) begin
        head_seq <= head_seq + SEQ_W'(1);
        wptr     <= wptr_inc;
      end
      if (state == ST_CALC) begin
        remaining <= (state_next == ST_DELIVER) ? c_n : '0;
        pend      <= 1'b0;
      end
      if (issue) begin
        remaining <= remaining - CNT_W'(1);
        pend      <= 1'b1;
      end else if (load_evt) begin
        pend <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take_query) begin
      q_beyond <= diff_wide[SEQ_W];
      q_diff   <= diff_wide[SEQ_W-1:0];
      q_since  <= since_seq;
      q_maxc   <= maxc_clamped;
    end
    if (state == ST_CALC) begin
      q_dropped <= c_dropped;
      rd_ptr    <= c_start;
      issue_seq <= c_since + SEQ_W'(1);
    end
    if (issue) begin
      rd_ptr    <= rd_ptr_inc;
      issue_seq <= issue_seq + SEQ_W'(1);
      pend_seq  <= issue_seq;
      pend_last <= (remaining == CNT_W'(1));
    end
    if (load_add) begin
      result_kind       <= KIND_ACK;
      event_payload_out <= '0;
      dropped_count     <= '0;
      last              <= 1'b1;
      if (head_seq == TOP_SEQ) begin
        accepted  <= 1'b0;
        event_seq <= head_seq;
        next_seq  <= head_seq;
      end else begin
        accepted  <= 1'b1;
        event_seq <= head_seq + SEQ_W'(1);
        next_seq  <= head_seq + SEQ_W'(1);
      end
    end
    if (load_term) begin
      result_kind       <= KIND_EMPTY;
      accepted          <= 1'b0;
      event_seq         <= '0;
      event_payload_out <= '0;
      next_seq          <= q_beyond ? head_seq : c_since;
      dropped_count     <= q_beyond ? '0 : c_dropped;
      last              <= 1'b1;
    end
    if (load_evt) begin
      result_kind       <= KIND_EVENT;
      accepted          <= 1'b0;
      event_seq         <= pend_seq;
      event_payload_out <= PORT_PL_W'(mem_rd_data);
      next_seq          <= pend_last ? pend_seq : '0;
      dropped_count     <= pend_last ? q_dropped : '0;
      last              <= pend_last;
    end
  end

`ifndef SYNTHESIS
  a_pend_in_deliver: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == ST_DELIVER))
    else $error("read data pending outside delivery");

  a_head_step: assert property (@(posedge clk) disable iff (rst)
    (load_add && (head_seq != TOP_SEQ)) |=> (head_seq == $past(head_seq) + SEQ_W'(1)))
    else $error("head sequence did not advance on a stored add");

  a_wptr_range: assert property (@(posedge clk) disable iff (rst)
    SUM_W'(wptr) < SUM_W'(RING_DEPTH))
    else $error("write pointer outside the ring");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last && (result_kind == KIND_EVENT)) |-> ((remaining == '0) && !pend))
    else $error("last event presented with delivery still outstanding");
`endif

endmodule

// ----- dv/ser_scoreboard_pkg.sv -----
`timescale 1ns / 1ps
// ser_scoreboard_pkg: result type and scoreboard for the sequenced event ring testbench.
// The scoreboard keeps its own ring, head and default payload to predict each result.
// Depends on ser_pkg.
package ser_scoreboard_pkg;
  import ser_pkg::*;

  localparam int RING_SLOTS = 64;
  localparam int PL_BITS    = 64;
  localparam logic [PORT_PL_W-1:0] PL_MASK =
    (PL_BITS >= PORT_PL_W) ? {PORT_PL_W{1'b1}} : ((64'd1 << PL_BITS) - 64'd1);

  typedef struct packed {
    logic [1:0]           kind;
    logic                 acc;
    logic [SEQ_W-1:0]     seq;
    logic [PORT_PL_W-1:0] payload;
    logic [SEQ_W-1:0]     nxt;
    logic [SEQ_W-1:0]     drop;
    logic                 fin;
  } ring_result_t;

  class event_ring_scoreboard;
    logic [PORT_PL_W-1:0] dflt;
    logic [PORT_PL_W-1:0] slots [RING_SLOTS];
    logic [SEQ_W-1:0]     head;
    ring_result_t         pending_results [$];
    int errors, adds, refused, queries, delivered, evicting, beyond, empties;

    function new();
      dflt = '0;
      head = '0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("[%0t] mismatch on %s: got %h, want %h", $time, field, got, want);
    endtask

    // Predict the results of one accepted transfer and queue them.
    function void note_input(logic op, logic [PORT_PL_W-1:0] pl, logic pres,
                             logic [SEQ_W-1:0] since, logic [COUNT_W-1:0] maxc);
      ring_result_t     r;
      logic [SEQ_W-1:0] from, oldest, avail, n, cnt, s, dropped;
      r = '0;
      if (op == OP_ADD) begin
        adds++;
        r.kind = KIND_ACK;
        r.fin  = 1'b1;
        if (head == TOP_SEQ) begin
          refused++;
          r.seq = head;
          r.nxt = head;
        end else begin
          slots[head % RING_SLOTS] = (pres ? pl : dflt) & PL_MASK;
          head  = head + 1;
          r.acc = 1'b1;
          r.seq = head;
          r.nxt = head;
        end
        pending_results.push_back(r);
        return;
      end
      queries++;
      cnt = (maxc > MAX_DELIVER) ? SEQ_W'(MAX_DELIVER) : SEQ_W'(maxc);
      if (since > head) begin
        beyond++;
        r.kind = KIND_EMPTY;
        r.nxt  = head;
        r.fin  = 1'b1;
        pending_results.push_back(r);
        return;
      end
      oldest  = (head > SEQ_W'(RING_SLOTS)) ? head - SEQ_W'(RING_SLOTS) : '0;
      from    = since;
      dropped = '0;
      if (from < oldest) begin
        evicting++;
        dropped = oldest - from;
        from    = oldest;
      end
      avail = head - from;
      n     = (avail < cnt) ? avail : cnt;
      if (n == 0) begin
        empties++;
        r.kind = KIND_EMPTY;
        r.nxt  = from;
        r.drop = dropped;
        r.fin  = 1'b1;
        pending_results.push_back(r);
        return;
      end
      for (int unsigned i = 0; i < n; i++) begin
        s         = from + 1 + i;
        r         = '0;
        r.kind    = KIND_EVENT;
        r.seq     = s;
        r.payload = slots[(s - 1) % RING_SLOTS];
        if (i + 1 == n) begin
          r.nxt  = s;
          r.drop = dropped;
          r.fin  = 1'b1;
        end
        pending_results.push_back(r);
        delivered++;
      end
    endfunction

    task check_result(logic [1:0] kind, logic acc, logic [SEQ_W-1:0] seq,
                      logic [PORT_PL_W-1:0] payload, logic [SEQ_W-1:0] nxt,
                      logic [SEQ_W-1:0] drop, logic fin);
      ring_result_t want;
      if (pending_results.size() == 0) begin
        report("result with nothing outstanding, event_seq", seq, 0);
        return;
      end
      want = pending_results.pop_front();
      if (kind !== want.kind)       report("result_kind", kind, want.kind);
      if (acc !== want.acc)         report("accepted", acc, want.acc);
      if (seq !== want.seq)         report("event_seq", seq, want.seq);
      if (payload !== want.payload) report("event_payload_out", payload, want.payload);
      if (nxt !== want.nxt)         report("next_seq", nxt, want.nxt);
      if (drop !== want.drop)       report("dropped_count", drop, want.drop);
      if (fin !== want.fin)         report("last", fin, want.fin);
    endtask
  endclass

endpackage

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// tb: top-level testbench for sequenced_event_ring, directed then random adds and queries.
// Drives both channels with random idling and checks every result via the scoreboard.
// Depends on ser_pkg and ser_scoreboard_pkg.
module tb;
  import ser_pkg::*;
  import ser_scoreboard_pkg::*;

  localparam int LIMIT = 400000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 operation = OP_ADD;
  logic [PORT_PL_W-1:0] event_payload_in = '0;
  logic                 payload_present = 1'b0;
  logic [SEQ_W-1:0]     since_seq = '0;
  logic [COUNT_W-1:0]   max_count = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           result_kind;
  logic                 accepted;
  logic [SEQ_W-1:0]     event_seq;
  logic [PORT_PL_W-1:0] event_payload_out;
  logic [SEQ_W-1:0]     next_seq;
  logic [SEQ_W-1:0]     dropped_count;
  logic                 last;
  logic                 cfg_wr_en = 1'b0;
  logic [PORT_PL_W-1:0] cfg_wr_data = '0;

  logic steady = 1'b0;  // no idling on either side while set
  int   cycles = 0;
  event_ring_scoreboard sb;

  sequenced_event_ring #(
    .RING_DEPTH  (RING_SLOTS),
    .PAYLOAD_BITS(PL_BITS)
  ) u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .event_payload_in (event_payload_in),
    .payload_present  (payload_present),
    .since_seq        (since_seq),
    .max_count        (max_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_kind      (result_kind),
    .accepted         (accepted),
    .event_seq        (event_seq),
    .event_payload_out(event_payload_out),
    .next_seq         (next_seq),
    .dropped_count    (dropped_count),
    .last             (last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, sb.pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // Result side: check each transfer, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_result(result_kind, accepted, event_seq, event_payload_out,
                        next_seq, dropped_count, last);
      out_stall <= !steady && ($urandom_range(0, 99) < 17);
    end
  end

  // Hold the item until it transfers; called at a rising edge.
  task automatic send(input logic op, input logic [PORT_PL_W-1:0] pl, input logic pres,
                      input logic [SEQ_W-1:0] since, input logic [COUNT_W-1:0] mc);
    while (!steady && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    operation        <= op;
    event_payload_in <= pl;
    payload_present  <= pres;
    since_seq        <= since;
    max_count        <= mc;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, pl, pres, since, mc);
  endtask

  task automatic random_item();
    logic               op, pres;
    logic [SEQ_W-1:0]   h, since;
    logic [COUNT_W-1:0] mc;
    int                 pick;
    h    = sb.head;
    op   = ($urandom_range(0, 99) < 50) ? OP_ADD : OP_READ;
    pres = $urandom_range(0, 99) < 75;
    pick = $urandom_range(0, 99);
    // Mostly readers close behind head; some far behind, ahead, or anywhere.
    if (pick < 55)      since = h - $urandom_range(0, (h < 12) ? h : 12);
    else if (pick < 70) since = h - $urandom_range(0, (h < 100) ? h : 100);
    else if (pick < 80) since = h + $urandom_range(1, 1000);
    else if (pick < 88) since = '0;
    else                since = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 50)      mc = COUNT_W'($urandom_range(0, 8));
    else if (pick < 80) mc = COUNT_W'($urandom_range(0, 64));
    else if (pick < 95) mc = COUNT_W'($urandom_range(65, 127));
    else                mc = '0;
    send(op, {$urandom, $urandom}, pres, since, mc);
  endtask

  // Hold off input until every predicted result has arrived, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_default(input logic [PORT_PL_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.dflt      = v;
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic [SEQ_W-1:0] h;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Empty ring, then reader ahead of head.
    send(OP_READ, '0, 1'b0, 32'd0, 7'd5);
    send(OP_READ, '0, 1'b0, 32'd1, 7'd5);
    send(OP_ADD, {PORT_PL_W{1'b1}}, 1'b1, '0, '0);
    send(OP_ADD, '0, 1'b1, '0, '0);
    send(OP_ADD, {$urandom, $urandom}, 1'b0, '0, '0);
    drain();
    write_default({PORT_PL_W{1'b1}});
    send(OP_ADD, 64'h0123_4567_89ab_cdef, 1'b0, {SEQ_W{1'b1}}, {COUNT_W{1'b1}});
    send(OP_ADD, {$urandom, $urandom}, 1'b1, '0, '0);
    send(OP_READ, '0, 1'b0, 32'd0, 7'd0);
    send(OP_READ, {PORT_PL_W{1'b1}}, 1'b1, 32'd0, 7'd127);
    send(OP_READ, '0, 1'b0, 32'd0, 7'd64);
    send(OP_READ, '0, 1'b0, 32'd2, 7'd1);
    send(OP_READ, '0, 1'b0, 32'd5, 7'd10);
    send(OP_READ, '0, 1'b0, {SEQ_W{1'b1}}, 7'd64);
    send(OP_READ, '0, 1'b0, 32'd4, 7'd65);

    // Wrap the ring so older events are evicted.
    for (int i = 0; i < 70; i++)
      send(OP_ADD, {$urandom, $urandom}, ($urandom_range(0, 3) != 0), $urandom,
           COUNT_W'($urandom));
    h = sb.head;
    send(OP_READ, '0, 1'b0, 32'd0, 7'd64);
    send(OP_READ, '0, 1'b0, 32'd0, 7'd0);
    send(OP_READ, '0, 1'b0, h - 65, 7'd3);
    send(OP_READ, '0, 1'b0, h - 64, 7'd100);

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0:       write_default({$urandom, $urandom});
        1:       write_default('0);
        2:       write_default({PORT_PL_W{1'b1}});
        default: write_default({$urandom, $urandom});
      endcase
      steady <= (phase == 1);
      for (int i = 0; i < 75; i++) random_item();
    end
    steady <= 1'b0;

    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d adds (%0d refused) and %0d queries: %0d events delivered,",
             sb.adds, sb.refused, sb.queries, sb.delivered);
    $display("%0d queries past evictions, %0d ahead of head, %0d empty; head at %0d",
             sb.evicting, sb.beyond, sb.empties, sb.head);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
